// File: rtl/core/aeg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeg_pkg
// Shared widths, register codes and types of the linear envelope generator.
// ----------------------------------------------------------------------------
package aeg_pkg;

  localparam int COUNT_BITS   = 24;
  localparam int SAMPLE_BITS  = 16;
  localparam int LEN_BITS     = 24;
  localparam int LVL_BITS     = 15;
  localparam int CFG_IDX_BITS = 3;
  localparam int TDATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CMP_W        = ((COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS) + 2;
  localparam int PROD_BITS    = LVL_BITS + LEN_BITS;
  localparam int SCALE_BITS   = SAMPLE_BITS + LVL_BITS + 1;
  localparam int STEP_BITS    = $clog2(LVL_BITS + 1);
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_BITS   = 1;
  localparam int Q_LVL_BITS   = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ENABLE,
    REG_ATTACK_LEN,
    REG_DECAY_LEN,
    REG_RELEASE_LEN,
    REG_DURATION,
    REG_PEAK_LEVEL,
    REG_SUSTAIN_LEVEL,
    REG_INPUT_CONNECTED
  } cfg_reg_e;

  typedef struct packed {
    logic                enable;
    logic [LEN_BITS-1:0] attack_len;
    logic [LEN_BITS-1:0] decay_len;
    logic [LEN_BITS-1:0] release_len;
    logic [LEN_BITS-1:0] duration;
    logic [LVL_BITS-1:0] peak_level;
    logic [LVL_BITS-1:0] sustain_level;
    logic                input_connected;
  } cfg_t;

  // one ramp evaluation: level = offset +/- (mag * elapsed) / len
  typedef struct packed {
    logic                          use_input;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          neg;
    logic [LVL_BITS-1:0]           mag;
    logic [LEN_BITS-1:0]           elapsed;
    logic [LEN_BITS-1:0]           len;
    logic [LVL_BITS-1:0]           offset;
  } job_t;

  typedef struct packed {
    logic                  full;
    logic                  empty;
    logic [Q_LVL_BITS-1:0] level;
  } q_stat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_PREP,
    B_DIV,
    B_SCALE,
    B_DONE
  } back_state_e;

endpackage

// File: rtl/core/aeg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeg_front
// Takes input beats, owns the sample counter and sorts each sample into its
// envelope phase, handing a ramp job to the queue.
// ----------------------------------------------------------------------------
module aeg_front (
  input  logic                           clk,
  input  logic                           rst,
  input  aeg_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [aeg_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                           in_hold,
  output logic                           push,
  output aeg_pkg::job_t                  job,
  input  logic                           q_full
);
  import aeg_pkg::*;

  logic                          busy;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          hold;
  logic [COUNT_BITS-1:0]         count;
  logic [COUNT_BITS-1:0]         count_next;

  logic [COUNT_BITS-1:0]  cnt_w;
  logic signed [CMP_W-1:0] c, att, dec, rel, dur, rstart;
  logic                   in_att, in_dec, in_rel, advance;

  assign push     = busy && !q_full;
  assign in_ready = !busy || push;

  always_comb begin
    att    = CMP_W'(cfg.attack_len);
    dec    = CMP_W'(cfg.decay_len);
    rel    = CMP_W'(cfg.release_len);
    dur    = CMP_W'(cfg.duration);
    cnt_w  = (CMP_W'(count) >= dur) ? '0 : count;
    c      = CMP_W'(cnt_w);
    rstart = dur - rel;
    in_att = c < att;
    in_dec = c < (att + dec);
    in_rel = c > rstart;

    advance       = 1'b1;
    job.use_input = cfg.input_connected;
    job.sample    = sample;
    job.neg       = 1'b0;
    job.mag       = '0;
    job.elapsed   = '0;
    job.len       = LEN_BITS'(1);
    job.offset    = cfg.sustain_level;

    if (in_rel) begin
      if (!hold) begin
        job.neg     = 1'b1;
        job.mag     = cfg.sustain_level;
        job.elapsed = LEN_BITS'(c - rstart);
        job.len     = cfg.release_len;
      end else begin
        advance = 1'b0;
      end
    end else if (in_att) begin
      job.mag     = cfg.peak_level;
      job.elapsed = LEN_BITS'(c);
      job.len     = cfg.attack_len;
      job.offset  = '0;
    end else if (in_dec) begin
      job.neg     = cfg.sustain_level < cfg.peak_level;
      job.mag     = job.neg ? (cfg.peak_level - cfg.sustain_level)
                            : (cfg.sustain_level - cfg.peak_level);
      job.elapsed = LEN_BITS'(c - att);
      job.len     = cfg.decay_len;
      job.offset  = cfg.peak_level;
    end

    count_next = advance ? (cnt_w + 1'b1) : cnt_w;

    // disabled: level zero, counter frozen
    if (!cfg.enable) begin
      job.use_input = 1'b0;
      job.neg       = 1'b0;
      job.mag       = '0;
      job.elapsed   = '0;
      job.len       = LEN_BITS'(1);
      job.offset    = '0;
      count_next    = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        count <= count_next;
      end
      if (in_valid && in_ready) begin
        busy <= 1'b1;
      end else if (push) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample <= in_sample;
      hold   <= in_hold;
    end
  end

endmodule

// File: rtl/core/aeg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeg_queue
// Two-entry job queue between the phase front and the divider back.
// ----------------------------------------------------------------------------
module aeg_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  aeg_pkg::job_t    wr_job,
  input  logic             pop,
  output aeg_pkg::job_t    rd_job,
  output aeg_pkg::q_stat_t stat
);
  import aeg_pkg::*;

  job_t                  mem [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [Q_LVL_BITS-1:0] level;

  assign stat.level = level;
  assign stat.full  = level == Q_LVL_BITS'(Q_DEPTH);
  assign stat.empty = level == '0;
  assign rd_job     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

endmodule

// File: rtl/core/aeg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeg_back
// Evaluates one ramp job: multiply, bit-serial restoring division, level
// offset, optional Q0.15 scaling of the sample and saturation.
// ----------------------------------------------------------------------------
module aeg_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_empty,
  input  aeg_pkg::job_t                          q_job,
  output logic                                   pop,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [aeg_pkg::SAMPLE_BITS-1:0] out_data
);
  import aeg_pkg::*;

  localparam logic signed [SCALE_BITS-1:0] SMAX =
    SCALE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SCALE_BITS-1:0] SMIN = -SMAX - SCALE_BITS'(1);

  back_state_e state, state_next;

  job_t                         job;
  logic [PROD_BITS-1:0]         prod;
  logic [LEN_BITS-1:0]          rem;
  logic [LVL_BITS-1:0]          qbits;
  logic [STEP_BITS-1:0]         step;
  logic [LVL_BITS-1:0]          lvl;
  logic signed [SCALE_BITS-1:0] scaled;

  logic [LEN_BITS+1:0]          trial;
  logic                         ge;
  logic [LVL_BITS:0]            lvl_sum;
  logic signed [SCALE_BITS-1:0] res, res_sat;
  logic                         out_load;

  always_comb begin
    trial   = {1'b0, rem, qbits[LVL_BITS-1]} - {2'b00, job.len};
    ge      = !trial[LEN_BITS+1];
    lvl_sum = job.neg ? ({1'b0, job.offset} - {1'b0, qbits})
                      : ({1'b0, job.offset} + {1'b0, qbits});
    res     = job.use_input ? (scaled >>> LVL_BITS) : $signed(SCALE_BITS'(lvl));
    if (res > SMAX) begin
      res_sat = SMAX;
    end else if (res < SMIN) begin
      res_sat = SMIN;
    end else begin
      res_sat = res;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = B_MUL;
        end
      end
      B_MUL:   state_next = B_PREP;
      B_PREP:  state_next = B_DIV;
      B_DIV: begin
        if (step == STEP_BITS'(LVL_BITS - 1)) begin
          state_next = B_SCALE;
        end
      end
      B_SCALE: state_next = B_DONE;
      B_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (pop) begin
          job <= q_job;
        end
      end
      B_MUL: begin
        prod <= job.mag * job.elapsed;
      end
      B_PREP: begin
        rem   <= prod[PROD_BITS-1:LVL_BITS];
        qbits <= prod[LVL_BITS-1:0];
        step  <= '0;
      end
      B_DIV: begin
        rem   <= ge ? trial[LEN_BITS-1:0] : {rem[LEN_BITS-2:0], qbits[LVL_BITS-1]};
        qbits <= {qbits[LVL_BITS-2:0], ge};
        step  <= step + 1'b1;
      end
      B_SCALE: begin
        lvl    <= lvl_sum[LVL_BITS-1:0];
        scaled <= job.sample * $signed({1'b0, lvl_sum[LVL_BITS-1:0]});
      end
      default: begin
        if (out_load) begin
          out_data <= res_sat[SAMPLE_BITS-1:0];
        end
      end
    endcase
  end

endmodule

// File: rtl/core/adsr_envelope_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_envelope_generator_unit
// Linear attack-decay-sustain-release envelope applied per audio sample.
//
//   channel  dir  handshake                    contents
//   s_axis   in   s_axis_tvalid/tready         tdata: sample; tuser: hold_sustain
//   m_axis   out  m_axis_tvalid/tready         tdata: out_sample
//   cfg      in   cfg_we                       cfg_index, cfg_data
//
// The front registers a beat and classifies it combinationally; the back
// handles one sample at a time (pop, multiply, divider load, 15 restoring
// division steps, level and scale, output), so the bit-serial divider sets
// the sustained rate. Reset clears the counter and loads duration 1; no
// clearing pass. The two-entry queue lets the front run ahead while the
// output register waits on m_axis_tready.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [aeg_pkg::TDATA_BITS-1:0]     s_axis_tdata,   // [15:0] sample
  input  logic                               s_axis_tuser,   // [0] hold_sustain
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [aeg_pkg::TDATA_BITS-1:0]     m_axis_tdata,   // [15:0] out_sample
  input  logic                               cfg_we,
  input  logic [aeg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [aeg_pkg::LEN_BITS-1:0]       cfg_data
);
  import aeg_pkg::*;

  cfg_t                          cfg;
  logic                          q_push, q_pop;
  job_t                          wr_job, rd_job;
  q_stat_t                       q_stat;
  logic signed [SAMPLE_BITS-1:0] out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable          <= 1'b0;
      cfg.attack_len      <= '0;
      cfg.decay_len       <= '0;
      cfg.release_len     <= '0;
      cfg.duration        <= LEN_BITS'(1);
      cfg.peak_level      <= '0;
      cfg.sustain_level   <= '0;
      cfg.input_connected <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_ENABLE:          cfg.enable          <= cfg_data[0];
        REG_ATTACK_LEN:      cfg.attack_len      <= cfg_data;
        REG_DECAY_LEN:       cfg.decay_len       <= cfg_data;
        REG_RELEASE_LEN:     cfg.release_len     <= cfg_data;
        REG_DURATION:        cfg.duration        <= cfg_data;
        REG_PEAK_LEVEL:      cfg.peak_level      <= cfg_data[LVL_BITS-1:0];
        REG_SUSTAIN_LEVEL:   cfg.sustain_level   <= cfg_data[LVL_BITS-1:0];
        REG_INPUT_CONNECTED: cfg.input_connected <= cfg_data[0];
        default: ;
      endcase
    end
  end

  aeg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_hold   (s_axis_tuser),
    .push      (q_push),
    .job       (wr_job),
    .q_full    (q_stat.full)
  );

  aeg_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (wr_job),
    .pop    (q_pop),
    .rd_job (rd_job),
    .stat   (q_stat)
  );

  aeg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_stat.empty),
    .q_job     (rd_job),
    .pop       (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = TDATA_BITS'($unsigned(out_data));

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("job queue read while empty");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.level <= Q_LVL_BITS'(Q_DEPTH))
    else $error("job queue level beyond depth");

  a_level_track: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |=> (q_stat.level == $past(q_stat.level) + 1'b1))
    else $error("job queue level lost a push");
`endif

endmodule

// File: tb/adsr_envelope_generator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_envelope_generator_unit_test
// Self-checking bench for the linear envelope generator. A table of directed
// beats and register writes covers the disabled state, the level extremes,
// scaling of full-scale samples, the attack/decay/sustain/release path with
// hold, a duration lowered below the counter, duration zero and a release
// longer than the duration. Random settings phases follow, each with random
// samples and hold flags, checked against a behavioral envelope predictor.
// Both stream sides idle at random; the sink holds off once for a long
// stretch so that the input stalls.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_unit_test;

  import aeg_pkg::*;

  localparam int          RANDOM_ITEMS   = 650;
  localparam int          PAUSE_AT       = 350;
  localparam int          HOLDOFF_AT     = 300;
  localparam int          HOLDOFF_CYCLES = 500;
  localparam int unsigned CYCLE_LIMIT    = 400000;

  typedef enum logic { ROW_WRITE, ROW_BEAT } row_kind_e;

  typedef struct {
    row_kind_e           kind;
    cfg_reg_e            idx;
    logic [LEN_BITS-1:0] value;
    logic [15:0]         smp;
    logic                hold;
    bit                  typed;
    logic [15:0]         out;
  } dir_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [TDATA_BITS-1:0]     s_axis_tdata = '0;   // [15:0] sample
  logic                      s_axis_tuser = 1'b0; // [0] hold_sustain
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [TDATA_BITS-1:0]     m_axis_tdata;        // [15:0] out_sample
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_index = REG_ENABLE;
  logic [LEN_BITS-1:0]       cfg_data = '0;

  // predictor copy of settings and counter
  logic                      env_enable;
  logic [LEN_BITS-1:0]       env_attack;
  logic [LEN_BITS-1:0]       env_decay;
  logic [LEN_BITS-1:0]       env_release;
  logic [LEN_BITS-1:0]       env_duration;
  logic [LVL_BITS-1:0]       env_peak;
  logic [LVL_BITS-1:0]       env_sustain;
  logic                      env_input_on;
  logic [COUNT_BITS-1:0]     env_count;

  logic [15:0]               pending_out[$];
  dir_row_t                  dir_rows[$];

  int unsigned               cycles = 0;
  int                        error_count = 0;
  int                        beats_sent = 0;
  int                        beats_checked = 0;
  int                        phases = 0;
  bit                        tx_burst = 0;
  bit                        rx_burst = 0;

  adsr_envelope_generator_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("adsr_envelope_generator_unit_test: errors");
      $finish;
    end
  end

  // envelope output for one sample; advances the predictor counter
  function automatic logic [15:0] envelope_out_for(input logic signed [15:0] smp,
                                                   input logic hold);
    longint cnt, att, dec, rel, pk, sus, rstart, lvl, res;
    bit     advance;
    if (!env_enable) return 16'h0000;
    if (env_count >= env_duration) env_count = '0;
    cnt    = longint'(env_count);
    att    = longint'(env_attack);
    dec    = longint'(env_decay);
    rel    = longint'(env_release);
    pk     = longint'(env_peak);
    sus    = longint'(env_sustain);
    rstart = longint'(env_duration) - rel;
    advance = 1'b1;
    if (cnt < att) lvl = (pk * cnt) / att;
    else if (cnt < att + dec) lvl = ((sus - pk) * (cnt - att)) / dec + pk;
    else lvl = sus;
    if (cnt > rstart) begin
      if (!hold) begin
        lvl = (-sus * (cnt - rstart)) / rel + sus;
      end else begin
        lvl = sus;
        advance = 1'b0;
      end
    end
    if (advance) env_count = env_count + 1'b1;
    if (env_input_on) res = (longint'(smp) * lvl) >>> 15;
    else res = lvl;
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[15:0];
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
  endtask

  task automatic write_setting(input cfg_reg_e idx, input logic [LEN_BITS-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    case (idx)
      REG_ENABLE:          env_enable   = value[0];
      REG_ATTACK_LEN:      env_attack   = value;
      REG_DECAY_LEN:       env_decay    = value;
      REG_RELEASE_LEN:     env_release  = value;
      REG_DURATION:        env_duration = value;
      REG_PEAK_LEVEL:      env_peak     = value[LVL_BITS-1:0];
      REG_SUSTAIN_LEVEL:   env_sustain  = value[LVL_BITS-1:0];
      REG_INPUT_CONNECTED: env_input_on = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_beat(input logic [15:0] smp, input logic hold,
                           input bit typed, input logic [15:0] typed_out);
    int          gap;
    logic [15:0] predicted;
    if ($urandom_range(0, 31) == 0) tx_burst = ~tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = smp;
    s_axis_tuser  = hold;
    do @(posedge clk); while (!s_axis_tready);
    predicted = envelope_out_for(smp, hold);
    pending_out.push_back(typed ? typed_out : predicted);
    beats_sent++;
  endtask

  task automatic add_write(input cfg_reg_e idx, input logic [LEN_BITS-1:0] value);
    dir_row_t r;
    r.kind = ROW_WRITE; r.idx = idx; r.value = value;
    r.smp = '0; r.hold = 1'b0; r.typed = 0; r.out = '0;
    dir_rows.push_back(r);
  endtask

  task automatic add_beat(input logic [15:0] smp, input logic hold,
                          input bit typed, input logic [15:0] out);
    dir_row_t r;
    r.kind = ROW_BEAT; r.idx = REG_ENABLE; r.value = '0;
    r.smp = smp; r.hold = hold; r.typed = typed; r.out = out;
    dir_rows.push_back(r);
  endtask

  function automatic logic [LEN_BITS-1:0] draw_length();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return LEN_BITS'($urandom);
      default: return LEN_BITS'($urandom_range(1, 30));
    endcase
  endfunction

  function automatic logic [LEN_BITS-1:0] draw_level();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 24'h007FFF;
      default: return LEN_BITS'($urandom_range(0, 32767));
    endcase
  endfunction

  // result sink: random gaps, one long hold-off
  initial begin : result_sink
    int          gap;
    bit          held_off;
    logic [15:0] want;
    held_off = 0;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_burst = ~rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 4);
      if (!held_off && beats_checked >= HOLDOFF_AT) begin
        gap = HOLDOFF_CYCLES;
        held_off = 1;
      end
      if (gap > 0) begin
        @(negedge clk);
        m_axis_tready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      if (pending_out.size() == 0) begin
        $error("unexpected beat: out_sample %0d", $signed(m_axis_tdata[15:0]));
        error_count++;
      end else begin
        want = pending_out.pop_front();
        if (m_axis_tdata[15:0] !== want) begin
          $error("out_sample: expected %0d, got %0d", $signed(want),
                 $signed(m_axis_tdata[15:0]));
          error_count++;
        end
      end
      beats_checked++;
    end
  end

  initial begin : stimulus
    int          n;
    int          random_sent;
    bit          paused;
    logic [15:0] smp;
    logic [LEN_BITS-1:0] dur;

    env_enable = 1'b0; env_attack = '0; env_decay = '0; env_release = '0;
    env_duration = 24'd1; env_peak = '0; env_sustain = '0; env_input_on = 1'b0;
    env_count = '0;
    random_sent = 0;
    paused = 0;

    // disabled after reset
    add_beat(16'h7FFF, 1'b0, 1, 16'h0000);
    add_beat(16'h8000, 1'b1, 1, 16'h0000);
    // duration one, all levels zero
    add_write(REG_ENABLE, 24'd1);
    add_beat(16'h1234, 1'b0, 1, 16'h0000);
    // full level, input ignored
    add_write(REG_PEAK_LEVEL, 24'h007FFF);
    add_write(REG_SUSTAIN_LEVEL, 24'h007FFF);
    add_beat(16'h8000, 1'b0, 1, 16'h7FFF);
    // full-scale samples scaled by full gain
    add_write(REG_INPUT_CONNECTED, 24'd1);
    add_beat(16'h8000, 1'b0, 1, 16'h8001);
    add_beat(16'h7FFF, 1'b1, 1, 16'h7FFE);
    // full envelope pass with hold in release
    add_write(REG_INPUT_CONNECTED, 24'd0);
    add_write(REG_SUSTAIN_LEVEL, 24'd12345);
    add_write(REG_ATTACK_LEN, 24'd3);
    add_write(REG_DECAY_LEN, 24'd3);
    add_write(REG_RELEASE_LEN, 24'd3);
    add_write(REG_DURATION, 24'd12);
    for (int i = 0; i < 13; i++) add_beat(16'h0000, (i == 10 || i == 11), 0, '0);
    // duration lowered below counter
    add_write(REG_DURATION, 24'd2);
    add_beat(16'h5555, 1'b0, 0, '0);
    // duration zero
    add_write(REG_DURATION, 24'd0);
    add_beat(16'hAAAA, 1'b0, 0, '0);
    // release longer than duration
    add_write(REG_RELEASE_LEN, 24'd20);
    add_write(REG_DURATION, 24'd10);
    add_beat(16'h0001, 1'b0, 0, '0);
    add_beat(16'hFFFF, 1'b0, 0, '0);
    add_write(REG_ENABLE, 24'd0);
    add_beat(16'h4321, 1'b0, 1, 16'h0000);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        wait_idle();
        write_setting(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        send_beat(dir_rows[i].smp, dir_rows[i].hold, dir_rows[i].typed, dir_rows[i].out);
      end
    end

    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 7))
        0:       dur = '0;
        1:       dur = '1;
        2:       dur = 24'd1;
        default: dur = LEN_BITS'($urandom_range(2, 80));
      endcase
      write_setting(REG_ATTACK_LEN, draw_length());
      write_setting(REG_DECAY_LEN, draw_length());
      write_setting(REG_RELEASE_LEN, draw_length());
      write_setting(REG_DURATION, dur);
      write_setting(REG_PEAK_LEVEL, draw_level());
      write_setting(REG_SUSTAIN_LEVEL, draw_level());
      write_setting(REG_INPUT_CONNECTED, LEN_BITS'($urandom_range(0, 1)));
      write_setting(REG_ENABLE, LEN_BITS'($urandom_range(0, 6) != 0));
      phases++;
      n = $urandom_range(25, 50);
      for (int i = 0; i < n; i++) begin
        if (!paused && random_sent >= PAUSE_AT) begin
          wait_idle();
          paused = 1;
        end
        case ($urandom_range(0, 7))
          0:       smp = 16'h8000;
          1:       smp = 16'h7FFF;
          default: smp = 16'($urandom);
        endcase
        send_beat(smp, ($urandom_range(0, 4) == 0), 0, '0);
        random_sent++;
      end
    end

    wait_idle();
    repeat (200) @(posedge clk);

    $display("beats sent %0d, checked %0d, over %0d directed rows and %0d random settings",
             beats_sent, beats_checked, dir_rows.size(), phases);
    $display("covered disabled, full-scale scaling, all envelope phases, hold and odd durations");
    if (error_count == 0) begin
      $display("adsr_envelope_generator_unit_test: clean");
    end else begin
      $display("adsr_envelope_generator_unit_test: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/aeg_pkg.sv
rtl/core/aeg_front.sv
rtl/core/aeg_queue.sv
rtl/core/aeg_back.sv
rtl/core/adsr_envelope_generator_unit.sv
tb/adsr_envelope_generator_unit_test.sv
